[sv/nts_pkg.sv]
package nts_pkg;

  localparam int NUM_PATTERNS = 8;
  localparam int PATTERN_LEN  = 7;
  localparam int ELEM_BITS    = 8;

  // Field widths fixed at the ports
  localparam int PORT_ELEM_W = 8;
  localparam int PORT_ELEMS  = 7;
  localparam int SLOT_W      = 3;
  localparam int SAD_W       = 11;
  localparam int IDX_OUT_W   = 3;
  localparam int PIU_W       = 4;
  localparam int CFG_IDX_W   = 1;

  localparam int IDX_W = $clog2(NUM_PATTERNS);
  localparam int CNT_W = $clog2(NUM_PATTERNS + 1);
  // PATTERN_LEN is at most 7, so three carry bits hold the full sum
  localparam int SUM_W = ELEM_BITS + 3;

  localparam logic [SAD_W-1:0] SAD_MAX = {SAD_W{1'b1}};

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PERFECT_SAD_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERNS_IN_USE   = 1'b1;

  localparam logic [SAD_W-1:0] LIMIT_RESET = '0;
  localparam logic [PIU_W-1:0] PIU_RESET   = 4'd8;

  typedef logic [ELEM_BITS-1:0] elem_t;
  typedef elem_t [PATTERN_LEN-1:0] pattern_t;

  typedef struct packed {
    logic              valid;
    logic              action;
    logic [SLOT_W-1:0] slot;
    pattern_t          elems;
    logic [IDX_W-1:0]  best;
    logic [SAD_W-1:0]  best_sad;
    logic              perfect;  // also marks the scan as finished
  } item_t;

  typedef struct packed {
    logic [SAD_W-1:0] limit;
    logic [CNT_W-1:0] scan_count;
  } cfg_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [PIU_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > NUM_PATTERNS) begin
      r = CNT_W'(NUM_PATTERNS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

[sv/nts_if.sv]
interface nts_req_if;
  import nts_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [SLOT_W-1:0]      pattern_slot;
  logic [PORT_ELEM_W-1:0] elem_0;
  logic [PORT_ELEM_W-1:0] elem_1;
  logic [PORT_ELEM_W-1:0] elem_2;
  logic [PORT_ELEM_W-1:0] elem_3;
  logic [PORT_ELEM_W-1:0] elem_4;
  logic [PORT_ELEM_W-1:0] elem_5;
  logic [PORT_ELEM_W-1:0] elem_6;

  modport source (output valid, action, pattern_slot, elem_0, elem_1, elem_2, elem_3,
                  elem_4, elem_5, elem_6, input ready);
  modport sink (input valid, action, pattern_slot, elem_0, elem_1, elem_2, elem_3,
                elem_4, elem_5, elem_6, output ready);
endinterface

interface nts_rsp_if;
  import nts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] best_index;
  logic [SAD_W-1:0]     best_sad;
  logic                 perfect_match;

  modport source (output valid, best_index, best_sad, perfect_match, input ready);
  modport sink (input valid, best_index, best_sad, perfect_match, output ready);
endinterface

[sv/nts_slot_unit.sv]
module nts_slot_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic [nts_pkg::IDX_W-1:0] unit_id,
  input  nts_pkg::cfg_t            cfg,
  input  nts_pkg::item_t           item_in,
  output nts_pkg::item_t           item_out
);
  import nts_pkg::*;

  item_t            a;
  item_t            b;
  logic [SAD_W-1:0] b_sad;
  logic [SAD_W-1:0] sad_next;
  pattern_t         store;

  always_ff @(posedge clk) begin
    if (rst) begin
      a.valid <= 1'b0;
    end else if (advance) begin
      a <= item_in;
    end
  end

  // A load writes this slot as it leaves stage A, so every classify keeps
  // its place in order relative to loads.
  always_ff @(posedge clk) begin
    if (advance && a.valid && a.action == ACT_LOAD && int'(a.slot) == int'(unit_id)) begin
      store <= a.elems;
    end
  end

  always_comb begin
    logic [SUM_W-1:0] acc;
    elem_t            d;
    acc = '0;
    for (int k = 0; k < PATTERN_LEN; k++) begin
      d = (store[k] > a.elems[k]) ? (store[k] - a.elems[k]) : (a.elems[k] - store[k]);
      acc = acc + SUM_W'(d);
    end
    // terms are non-negative, so clipping the total equals clipping each step
    if (32'(acc) > 32'(SAD_MAX)) begin
      sad_next = SAD_MAX;
    end else begin
      sad_next = SAD_W'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b.valid <= 1'b0;
    end else if (advance) begin
      b     <= a;
      b_sad <= sad_next;
    end
  end

  always_comb begin
    logic active;
    item_out = b;
    active = b.action == ACT_CLASSIFY && !b.perfect &&
             int'(unit_id) < int'(cfg.scan_count);
    if (active) begin
      if (unit_id == '0 || b_sad < b.best_sad) begin
        item_out.best     = unit_id;
        item_out.best_sad = b_sad;
      end
      if (b_sad <= cfg.limit) begin
        item_out.perfect = 1'b1;
      end
    end
  end

endmodule

[sv/nearest_template_sad_classifier_unit.sv]
// Nearest-template SAD classifier. One beat enters per cycle while the result
// side is not stalled: a load beat writes a pattern slot, a classify beat returns
// the best slot, its SAD and the perfect flag. Each slot has its own two-stage unit
// (SAD, then compare); a beat passes every slot unit in turn and then the output
// register, and a new beat can enter before earlier ones are through.
// Loads travel down the same chain and update their slot as they pass it, so
// results follow the order of beats exactly. A stall on the result side holds
// the whole chain. Slots must be loaded before a classify reads them.
module nearest_template_sad_classifier_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [nts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nts_pkg::SAD_W-1:0]    cfg_wdata,
  nts_req_if.sink                      req,
  nts_rsp_if.source                    rsp
);
  import nts_pkg::*;

  logic [SAD_W-1:0]       limit;
  logic [CNT_W-1:0]       scan_count;
  cfg_t                   cfg;
  logic                   advance;
  item_t                  chain [NUM_PATTERNS+1];
  logic [PORT_ELEM_W-1:0] raw [PORT_ELEMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= LIMIT_RESET;
      scan_count <= clamp_count(PIU_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERFECT_SAD_LIMIT: limit <= cfg_wdata;
        CFG_PATTERNS_IN_USE:   scan_count <= clamp_count(cfg_wdata[PIU_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg.limit      = limit;
  assign cfg.scan_count = scan_count;

  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance;

  assign raw[0] = req.elem_0;
  assign raw[1] = req.elem_1;
  assign raw[2] = req.elem_2;
  assign raw[3] = req.elem_3;
  assign raw[4] = req.elem_4;
  assign raw[5] = req.elem_5;
  assign raw[6] = req.elem_6;

  always_comb begin
    chain[0].valid    = req.valid;
    chain[0].action   = req.action;
    chain[0].slot     = req.pattern_slot;
    chain[0].best     = '0;
    chain[0].best_sad = '0;
    chain[0].perfect  = 1'b0;
    for (int k = 0; k < PATTERN_LEN; k++) begin
      chain[0].elems[k] = ELEM_BITS'(raw[k]);
    end
  end

  for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_slot
    nts_slot_unit u_slot (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .unit_id  (IDX_W'(i)),
      .cfg      (cfg),
      .item_in  (chain[i]),
      .item_out (chain[i+1])
    );
  end

  // Loads drop out here; only classify beats become results.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= chain[NUM_PATTERNS].valid && chain[NUM_PATTERNS].action == ACT_CLASSIFY;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.best_index    <= IDX_OUT_W'(chain[NUM_PATTERNS].best);
      rsp.best_sad      <= chain[NUM_PATTERNS].best_sad;
      rsp.perfect_match <= chain[NUM_PATTERNS].perfect;
    end
  end

endmodule

[sv/nts_checker.sv]
module nts_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [nts_pkg::IDX_OUT_W-1:0] best_index,
  input logic [nts_pkg::SAD_W-1:0]    best_sad,
  input logic                         perfect_match
);
  import nts_pkg::*;

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(best_index) &&
    $stable(best_sad) && $stable(perfect_match))
    else $error("result beat changed while stalled");

  // input side runs whenever the result side is not blocked
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("input ready does not track result backpressure");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind nearest_template_sad_classifier_unit nts_checker u_nts_checker (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .best_index    (rsp.best_index),
  .best_sad      (rsp.best_sad),
  .perfect_match (rsp.perfect_match)
);

[sim/nearest_template_sad_classifier_unit_tb.sv]
module nearest_template_sad_classifier_unit_tb;
  import nts_pkg::*;

  localparam int PHASE_BEATS   = 148;
  localparam int PHASES        = 9;
  localparam int MAX_IDLE      = 12;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 400000;

  typedef logic [PORT_ELEMS-1:0][PORT_ELEM_W-1:0] elems_t;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot;
    elems_t            elems;
  } beat_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic [SAD_W-1:0]     sad;
    logic                 perfect;
  } verdict_t;

  class sad_scoreboard;
    elems_t           slots [NUM_PATTERNS];
    logic [SAD_W-1:0] limit;
    logic [PIU_W-1:0] scan_setting;
    verdict_t         awaited [$];
    int errors;
    int loads;
    int classifies;
    int perfects;
    int checked;

    function new();
      limit = LIMIT_RESET;
      scan_setting = PIU_RESET;
      errors = 0;
      loads = 0;
      classifies = 0;
      perfects = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAD_W-1:0] data);
      if (idx == CFG_PERFECT_SAD_LIMIT) begin
        limit = data;
      end else begin
        scan_setting = data[PIU_W-1:0];
      end
    endfunction

    function logic [SAD_W-1:0] slot_distance(int s, elems_t rd);
      int sum;
      int d;
      sum = 0;
      for (int k = 0; k < PATTERN_LEN; k++) begin
        d = int'(slots[s][k]) - int'(rd[k]);
        if (d < 0) d = -d;
        sum += d;
        if (sum > int'(SAD_MAX)) sum = int'(SAD_MAX);
      end
      return sum[SAD_W-1:0];
    endfunction

    // scan stops at the first slot within the limit; earlier slot wins ties
    function verdict_t nearest(elems_t rd);
      verdict_t v;
      int span;
      logic [SAD_W-1:0] d;
      v = '0;
      span = int'(scan_setting);
      if (span < 1) span = 1;
      if (span > NUM_PATTERNS) span = NUM_PATTERNS;
      for (int s = 0; s < span; s++) begin
        d = slot_distance(s, rd);
        if (s == 0 || d < v.sad) begin
          v.index = s[IDX_OUT_W-1:0];
          v.sad = d;
        end
        if (d <= limit) begin
          v.perfect = 1'b1;
          break;
        end
      end
      return v;
    endfunction

    function void note_input(beat_t b);
      if (b.action == ACT_LOAD) begin
        slots[b.slot] = b.elems;
        loads++;
      end else begin
        awaited.push_back(nearest(b.elems));
        classifies++;
      end
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      checked++;
      if (got.perfect === 1'b1) perfects++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: index %0d sad %0d perfect %0d",
                   got.index, got.sad, got.perfect);
        return;
      end
      want = awaited.pop_front();
      if (got.index !== want.index || got.sad !== want.sad || got.perfect !== want.perfect)
      begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want index %0d sad %0d perfect %0d, got index %0d sad %0d perfect %0d",
                   want.index, want.sad, want.perfect, got.index, got.sad, got.perfect);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAD_W-1:0]     cfg_wdata;

  nts_req_if req_ch ();
  nts_rsp_if rsp_ch ();

  sad_scoreboard book;
  bit send_gaps;
  bit take_gaps;
  int cycles = 0;
  int settings_used = 0;

  nearest_template_sad_classifier_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", book.awaited.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic elems_t random_elems();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[55:0];
  endfunction

  function automatic beat_t make_beat(logic act, int slot, elems_t e);
    beat_t b;
    b.action = act;
    b.slot = slot[SLOT_W-1:0];
    b.elems = e;
    return b;
  endfunction

  // mostly readings and patterns close to what is stored, so that small SADs,
  // ties and early stops come up often
  function automatic beat_t random_beat();
    beat_t b;
    int pick;
    int amp;
    int v;
    b.action = ($urandom_range(0, 99) < 22) ? ACT_LOAD : ACT_CLASSIFY;
    b.slot = SLOT_W'($urandom_range(0, NUM_PATTERNS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      b.elems = random_elems();
    end else begin
      b.elems = book.slots[$urandom_range(0, NUM_PATTERNS - 1)];
      amp = (pick < 35) ? 0 : ((pick < 80) ? 4 : 40);
      for (int k = 0; k < PORT_ELEMS; k++) begin
        v = int'(b.elems[k]) + int'($urandom_range(0, 2 * amp)) - amp;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        b.elems[k] = v[7:0];
      end
    end
    return b;
  endfunction

  // valid stays high after a beat so back-to-back beats need no second update
  task automatic send_beat(input beat_t b);
    int gap;
    gap = send_gaps ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= b.action;
    req_ch.pattern_slot <= b.slot;
    req_ch.elem_0       <= b.elems[0];
    req_ch.elem_1       <= b.elems[1];
    req_ch.elem_2       <= b.elems[2];
    req_ch.elem_3       <= b.elems[3];
    req_ch.elem_4       <= b.elems[4];
    req_ch.elem_5       <= b.elems[5];
    req_ch.elem_6       <= b.elems[6];
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    book.note_input(b);
  endtask

  // loads give no result, so the settle also lets the last load clear the chain
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input logic [SAD_W-1:0] lim, input logic [SAD_W-1:0] span_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PERFECT_SAD_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    book.write_reg(CFG_PERFECT_SAD_LIMIT, lim);
    cfg_index <= CFG_PATTERNS_IN_USE;
    cfg_wdata <= span_word;
    @(posedge clk);
    book.write_reg(CFG_PATTERNS_IN_USE, span_word);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : responder
    int stall;
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = take_gaps ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      book.check_result(verdict_t'({rsp_ch.best_index, rsp_ch.best_sad, rsp_ch.perfect_match}));
    end
  end

  initial begin : stimulus
    int limit_plan [PHASES] = '{0, 1785, 2047, 0, 40, 0, 100, 0, 1};
    int span_plan [PHASES]  = '{8, 8, 3, 0, 15, 0, 5, 9, 2};
    int drain_at;
    logic [SAD_W-1:0] span_word;

    book = new();
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_PERFECT_SAD_LIMIT;
    cfg_wdata           <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= ACT_LOAD;
    req_ch.pattern_slot <= '0;
    req_ch.elem_0       <= '0;
    req_ch.elem_1       <= '0;
    req_ch.elem_2       <= '0;
    req_ch.elem_3       <= '0;
    req_ch.elem_4       <= '0;
    req_ch.elem_5       <= '0;
    req_ch.elem_6       <= '0;
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every slot is loaded before the first classify; reset settings apply
    send_beat(make_beat(ACT_LOAD, 0, '0));
    send_beat(make_beat(ACT_LOAD, 1, {PORT_ELEMS{8'hFF}}));
    send_beat(make_beat(ACT_LOAD, 2, 56'h55AA55AA55AA55));
    send_beat(make_beat(ACT_LOAD, 3, 56'h07060504030201));
    send_beat(make_beat(ACT_LOAD, 4, 56'h07060504030201));
    send_beat(make_beat(ACT_LOAD, 5, random_elems()));
    send_beat(make_beat(ACT_LOAD, 6, {PORT_ELEMS{8'h80}}));
    send_beat(make_beat(ACT_LOAD, 7, 56'h0F1E2D3C4B5A69));
    send_beat(make_beat(ACT_CLASSIFY, 7, '0));
    send_beat(make_beat(ACT_CLASSIFY, 0, {PORT_ELEMS{8'hFF}}));
    send_beat(make_beat(ACT_CLASSIFY, 5, 56'h07060504030201));
    // equal SAD on slots 3 and 4, no exact hit
    send_beat(make_beat(ACT_CLASSIFY, 2, 56'h07060504030202));
    send_beat(make_beat(ACT_CLASSIFY, 6, {PORT_ELEMS{8'h7F}}));
    send_beat(make_beat(ACT_CLASSIFY, 3, random_elems()));
    send_beat(make_beat(ACT_CLASSIFY, 1, 56'hAA55AA55AA55AA));
    send_beat(make_beat(ACT_LOAD, 0, {PORT_ELEMS{8'h01}}));
    send_beat(make_beat(ACT_CLASSIFY, 4, '0));
    send_beat(make_beat(ACT_CLASSIFY, 6, {PORT_ELEMS{8'hFF}}));
    drain();

    limit_plan[5] = $urandom_range(0, 300);
    span_plan[5]  = $urandom_range(1, NUM_PATTERNS);
    limit_plan[7] = $urandom_range(0, 2047);

    for (int phase = 0; phase < PHASES; phase++) begin
      // upper data bits are don't-care for the scan length register
      span_word = {7'($urandom_range(0, 127)), 4'(span_plan[phase])};
      set_registers(limit_plan[phase][SAD_W-1:0], span_word);
      send_gaps = (phase % 3) != 2;
      take_gaps = (phase % 4) != 1;
      drain_at = $urandom_range(20, PHASE_BEATS - 20);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n == drain_at) drain();
        send_beat(random_beat());
      end
      drain();
    end

    $display("run: %0d beats (%0d loads, %0d classifies) over %0d register settings",
             book.loads + book.classifies, book.loads, book.classifies, settings_used + 1);
    $display("run: %0d results checked, %0d stopped on a perfect match, %0d failures",
             book.checked, book.perfects, book.errors);
    if (book.errors == 0 && book.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
